// File: design/spq_pkg.sv
// Shared constants, types and a helper function of the sorted priority queue.
package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int PRIO_W  = 16;
  localparam int ENTRY_W = DATA_W + PRIO_W;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;
  localparam int OCC_W   = 5;

  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK,
    RES_OVERFLOW,
    RES_EMPTY,
    RES_FRONT
  } res_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the incoming item, insertion point starts at the rear
    logic rd_front;  // read the front entry
    logic rd_prev;   // read the entry just ahead of the insertion point
    logic shift_wr;  // move the entry just read one place back
    logic item_wr;   // write the captured item at the insertion point
    logic pop;       // drop the front entry
    res_e res;       // which result to present
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic pos_one;
    logic greater;
  } stat_t;

  // Physical slot of a logical position in the ring, counted from the head.
  function automatic logic [AW-1:0] ring_addr(logic [AW-1:0] base, logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW + 1)'(DEPTH)) begin
      sum = sum - (AW + 1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage

// File: design/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/spq_dp.sv
// Datapath of the sorted priority queue: entry store, ring pointers and result registers.
module spq_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spq_pkg::cmd_t                     cmd_i,
  input  logic signed [spq_pkg::DATA_W-1:0] item_data_i,
  input  logic signed [spq_pkg::PRIO_W-1:0] item_priority_i,
  output spq_pkg::stat_t                    stat_o,
  output logic [spq_pkg::ST_W-1:0]          status_o,
  output logic signed [spq_pkg::DATA_W-1:0] out_data_o,
  output logic signed [spq_pkg::PRIO_W-1:0] out_priority_o,
  output logic [spq_pkg::OCC_W-1:0]         occupancy_o
);

  logic [spq_pkg::AW-1:0] head_q, head_d;
  logic [spq_pkg::CW-1:0] count_q, count_d;
  logic [spq_pkg::AW-1:0] pos_q, pos_d;
  logic signed [spq_pkg::DATA_W-1:0] item_data_q;
  logic signed [spq_pkg::PRIO_W-1:0] item_prio_q;

  logic [spq_pkg::ST_W-1:0]          status_q;
  logic signed [spq_pkg::DATA_W-1:0] out_data_q;
  logic signed [spq_pkg::PRIO_W-1:0] out_prio_q;
  logic [spq_pkg::OCC_W-1:0]         occ_q;

  logic                          ram_we, ram_re;
  logic [spq_pkg::AW-1:0]        ram_waddr, ram_raddr;
  logic [spq_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
  logic signed [spq_pkg::DATA_W-1:0] rd_data;
  logic signed [spq_pkg::PRIO_W-1:0] rd_prio;

  spq_ram #(
    .WIDTH(spq_pkg::ENTRY_W),
    .DEPTH(spq_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_data = ram_rdata[spq_pkg::ENTRY_W-1:spq_pkg::PRIO_W];
  assign rd_prio = ram_rdata[spq_pkg::PRIO_W-1:0];

  always_comb begin
    ram_re    = cmd_i.rd_front | cmd_i.rd_prev;
    ram_raddr = cmd_i.rd_front ? head_q
                               : spq_pkg::ring_addr(head_q, pos_q - spq_pkg::AW'(1));
    ram_we    = cmd_i.shift_wr | cmd_i.item_wr;
    ram_waddr = spq_pkg::ring_addr(head_q, pos_q);
    ram_wdata = cmd_i.shift_wr ? ram_rdata : {item_data_q, item_prio_q};
  end

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    pos_d   = pos_q;
    if (cmd_i.item_wr) begin
      count_d = count_q + spq_pkg::CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - spq_pkg::CW'(1);
      head_d  = spq_pkg::ring_addr(head_q, spq_pkg::AW'(1));
    end
    if (cmd_i.load) begin
      pos_d = spq_pkg::AW'(count_q);
    end else if (cmd_i.shift_wr) begin
      pos_d = pos_q - spq_pkg::AW'(1);
    end
  end

  always_comb begin
    stat_o.empty   = (count_q == '0);
    stat_o.full    = (count_q == spq_pkg::CW'(spq_pkg::DEPTH));
    stat_o.pos_one = (pos_q == spq_pkg::AW'(1));
    stat_o.greater = (rd_prio > item_prio_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (cmd_i.load) begin
      item_data_q <= item_data_i;
      item_prio_q <= item_priority_i;
    end
    occ_q <= spq_pkg::OCC_W'(count_d);
    unique case (cmd_i.res)
      spq_pkg::RES_NONE: begin
        status_q <= status_q;
      end
      spq_pkg::RES_OK: begin
        status_q   <= spq_pkg::ST_OK;
        out_data_q <= '0;
        out_prio_q <= '0;
      end
      spq_pkg::RES_OVERFLOW: begin
        status_q   <= spq_pkg::ST_OVERFLOW;
        out_data_q <= '0;
        out_prio_q <= '0;
      end
      spq_pkg::RES_EMPTY: begin
        status_q   <= spq_pkg::ST_EMPTY;
        out_data_q <= '0;
        out_prio_q <= '0;
      end
      spq_pkg::RES_FRONT: begin
        status_q   <= spq_pkg::ST_OK;
        out_data_q <= rd_data;
        out_prio_q <= rd_prio;
      end
      default: begin
        status_q <= status_q;
      end
    endcase
  end

  assign status_o       = status_q;
  assign out_data_o     = out_data_q;
  assign out_priority_o = out_prio_q;
  assign occupancy_o    = occ_q;

endmodule

// File: design/spq_ctrl.sv
// Controller state machine of the sorted priority queue.
module spq_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [spq_pkg::OP_W-1:0]   op_i,
  input  spq_pkg::stat_t             stat_i,
  output spq_pkg::cmd_t              cmd_o,
  output logic                       busy_o,
  output logic                       done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_READ,
    S_ENQ_CMP,
    S_ENQ_LAST,
    S_FRONT_OUT
  } state_e;

  state_e state_q, state_d;
  logic   pop_q, pop_d;
  logic   done_q;

  always_comb begin
    cmd_o   = '0;
    cmd_o.res = spq_pkg::RES_NONE;
    state_d = state_q;
    pop_d   = pop_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (op_i) inside
            spq_pkg::OP_ENQ: begin
              if (stat_i.full) begin
                cmd_o.res = spq_pkg::RES_OVERFLOW;
              end else begin
                cmd_o.load = 1'b1;
                state_d    = stat_i.empty ? S_ENQ_LAST : S_ENQ_READ;
              end
            end
            spq_pkg::OP_DEQ, spq_pkg::OP_PEEK: begin
              if (stat_i.empty) begin
                cmd_o.res = spq_pkg::RES_EMPTY;
              end else begin
                cmd_o.rd_front = 1'b1;
                pop_d          = (op_i == spq_pkg::OP_DEQ);
                state_d        = S_FRONT_OUT;
              end
            end
            spq_pkg::OP_NOP: begin
              cmd_o.res = spq_pkg::RES_OK;
            end
            default: begin
              cmd_o.res = spq_pkg::RES_OK;
            end
          endcase
        end
      end
      S_ENQ_READ: begin
        cmd_o.rd_prev = 1'b1;
        state_d       = S_ENQ_CMP;
      end
      S_ENQ_CMP: begin
        if (stat_i.greater) begin
          cmd_o.shift_wr = 1'b1;
          state_d        = stat_i.pos_one ? S_ENQ_LAST : S_ENQ_READ;
        end else begin
          cmd_o.item_wr = 1'b1;
          cmd_o.res     = spq_pkg::RES_OK;
          state_d       = S_IDLE;
        end
      end
      S_ENQ_LAST: begin
        cmd_o.item_wr = 1'b1;
        cmd_o.res     = spq_pkg::RES_OK;
        state_d       = S_IDLE;
      end
      S_FRONT_OUT: begin
        cmd_o.pop = pop_q;
        cmd_o.res = spq_pkg::RES_FRONT;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pop_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pop_q   <= pop_d;
      done_q  <= (cmd_o.res != spq_pkg::RES_NONE);
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// File: design/sorted_priority_queue.sv
// Top level of the sorted priority queue: controller and datapath.
//
// The block keeps up to DEPTH (data, priority) entries in ascending order of
// signed priority; entries of equal priority leave in arrival order.
// A command transfer happens at a rising edge where start_i is high and busy_o
// is low; op_i selects enqueue, dequeue, peek or no operation.
// Every command gives exactly one result, shown for one cycle with done_o high,
// carrying status_o, out_data_o, out_priority_o and occupancy_o. The receiver
// cannot stall, so the result transfer always completes in that cycle.
// Entries live in one RAM used as a ring: the head pointer moves on dequeue, so
// removal costs no shifting. No operation, overflow and underflow answer from idle;
// peek and dequeue first do one registered RAM read of the front entry. An enqueue
// into an empty store writes the item straight to the front; otherwise it walks
// from the rear, reading the entry ahead of the insertion point and then comparing
// it, moving it one place back while its priority is strictly larger; reading and
// comparing are separate steps, since the single RAM read port with registered
// data sets the pace. The item is written where the walk stops, or at the front.
// busy_o is low again in the cycle that shows the result, so the next command
// can transfer then. Reset empties the queue at once; stored words are not cleared.
module sorted_priority_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [spq_pkg::OP_W-1:0]          op_i,
  input  logic signed [spq_pkg::DATA_W-1:0] item_data_i,
  input  logic signed [spq_pkg::PRIO_W-1:0] item_priority_i,
  output logic                              done_o,
  output logic [spq_pkg::ST_W-1:0]          status_o,
  output logic signed [spq_pkg::DATA_W-1:0] out_data_o,
  output logic signed [spq_pkg::PRIO_W-1:0] out_priority_o,
  output logic [spq_pkg::OCC_W-1:0]         occupancy_o
);

  // Commands flow from the controller; status such as empty, full and the
  // priority compare flows back.
  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .op_i   (op_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  spq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_data_i    (item_data_i),
    .item_priority_i(item_priority_i),
    .stat_o         (stat),
    .status_o       (status_o),
    .out_data_o     (out_data_o),
    .out_priority_o (out_priority_o),
    .occupancy_o    (occupancy_o)
  );

endmodule

// File: design/spq_checker.sv
// Port-level assertions for the sorted priority queue, bound to the top level.
module spq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic [spq_pkg::OP_W-1:0]          op_i,
  input logic                              done_o,
  input logic [spq_pkg::ST_W-1:0]          status_o,
  input logic signed [spq_pkg::DATA_W-1:0] out_data_o,
  input logic signed [spq_pkg::PRIO_W-1:0] out_priority_o,
  input logic [spq_pkg::OCC_W-1:0]         occupancy_o
);

  // A result marks the end of a command, so the block is ready again.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // A no-operation command answers in the very next cycle with status ok.
  a_nop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && op_i == spq_pkg::OP_NOP)
    |=> (done_o && status_o == spq_pkg::ST_OK))
    else $error("no-operation command did not answer next cycle");

  // Overflow only happens with a full store.
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == spq_pkg::ST_OVERFLOW)
    |-> (occupancy_o == spq_pkg::OCC_W'(spq_pkg::DEPTH)))
    else $error("overflow reported with free space");

  // Underflow only happens on an empty store and carries zero payload.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == spq_pkg::ST_EMPTY)
    |-> (occupancy_o == '0 && out_data_o == '0 && out_priority_o == '0))
    else $error("underflow result not clean");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .op_i          (op_i),
  .done_o        (done_o),
  .status_o      (status_o),
  .out_data_o    (out_data_o),
  .out_priority_o(out_priority_o),
  .occupancy_o   (occupancy_o)
);

// File: verif/tb_top.sv
// Self-checking testbench for the sorted priority queue: directed rows, then random traffic.
module tb_top;
  import spq_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] data;
    logic signed [PRIO_W-1:0] prio;
    logic [OCC_W-1:0]         occ;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] data;
    logic signed [PRIO_W-1:0] prio;
    logic                     pinned;
    result_t                  want;
  } row_t;

  typedef enum int {FILLING, DRAINING, MIXED} mix_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [OP_W-1:0]          op_i;
  logic signed [DATA_W-1:0] item_data_i;
  logic signed [PRIO_W-1:0] item_priority_i;
  logic                     done_o;
  logic [ST_W-1:0]          status_o;
  logic signed [DATA_W-1:0] out_data_o;
  logic signed [PRIO_W-1:0] out_priority_o;
  logic [OCC_W-1:0]         occupancy_o;

  // Shadow copy of the sorted store, front entry at index 0.
  logic signed [DATA_W-1:0] shadow_data [DEPTH];
  logic signed [PRIO_W-1:0] shadow_prio [DEPTH];
  int                       shadow_cnt;

  result_t pending_q [$];
  row_t    directed_rows [$];
  int      err_cnt;

  sorted_priority_queue u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .item_data_i    (item_data_i),
    .item_priority_i(item_priority_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_data_o     (out_data_o),
    .out_priority_o (out_priority_o),
    .occupancy_o    (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Applies one command to the shadow store and returns the result it gives.
  task automatic queue_apply(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] d,
                             input logic signed [PRIO_W-1:0] p, output result_t r);
    int pos;
    r.status = ST_OK;
    r.data   = '0;
    r.prio   = '0;
    case (op)
      OP_ENQ: begin
        if (shadow_cnt >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          // Walk from the rear past every entry with a strictly larger priority.
          pos = shadow_cnt;
          while (pos > 0 && shadow_prio[pos-1] > p) begin
            shadow_data[pos] = shadow_data[pos-1];
            shadow_prio[pos] = shadow_prio[pos-1];
            pos--;
          end
          shadow_data[pos] = d;
          shadow_prio[pos] = p;
          shadow_cnt++;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (shadow_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = shadow_data[0];
          r.prio = shadow_prio[0];
          if (op == OP_DEQ) begin
            for (int k = 1; k < shadow_cnt; k++) begin
              shadow_data[k-1] = shadow_data[k];
              shadow_prio[k-1] = shadow_prio[k];
            end
            shadow_cnt--;
          end
        end
      end
      default: ;
    endcase
    r.occ = OCC_W'(shadow_cnt);
  endtask

  // Presents one command, waits for its transfer and records the result it owes.
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] d,
                          input logic signed [PRIO_W-1:0] p, input int idle_pct,
                          input logic pinned, input result_t pin_r);
    result_t r;
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk_i);
    end
    start_i         = 1'b1;
    op_i            = op;
    item_data_i     = d;
    item_priority_i = p;
    do @(posedge clk_i); while (busy_o);
    queue_apply(op, d, p, r);
    pending_q.push_back(pinned ? pin_r : r);
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] d,
                         input logic [PRIO_W-1:0] p, input logic pinned,
                         input logic [ST_W-1:0] st, input logic [OCC_W-1:0] occ);
    row_t row;
    row.op          = op;
    row.data        = d;
    row.prio        = p;
    row.pinned      = pinned;
    row.want.status = st;
    row.want.data   = '0;
    row.want.prio   = '0;
    row.want.occ    = occ;
    directed_rows.push_back(row);
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result: status %0d data %0d prio %0d occ %0d", $time,
                 status_o, out_data_o, out_priority_o, occupancy_o);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          err_cnt++;
        end
        if (out_data_o !== want.data) begin
          $display("%0t: out_data expected %0d actual %0d", $time, want.data, out_data_o);
          err_cnt++;
        end
        if (out_priority_o !== want.prio) begin
          $display("%0t: out_priority expected %0d actual %0d", $time, want.prio,
                   out_priority_o);
          err_cnt++;
        end
        if (occupancy_o !== want.occ) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, occupancy_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    result_t                  no_pin;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] d;
    logic signed [PRIO_W-1:0] p;
    mix_e                     mix;
    int                       mix_left;
    int                       idle_pct;
    int                       enq_pct;
    int                       peek_pct;
    int                       roll;

    rst_ni          = 1'b0;
    start_i         = 1'b0;
    op_i            = OP_NOP;
    item_data_i     = '0;
    item_priority_i = '0;
    err_cnt         = 0;
    shadow_cnt      = 0;
    no_pin          = '0;
    mix             = MIXED;
    mix_left        = 0;

    // Empty store, the no-operation command, extreme fields and ties, then fill to overflow.
    add_row(OP_DEQ,  32'h0,        16'h0,    1'b1, ST_EMPTY, 0);
    add_row(OP_PEEK, 32'h0,        16'h0,    1'b1, ST_EMPTY, 0);
    add_row(OP_NOP,  32'hffffffff, 16'hffff, 1'b1, ST_OK,    0);
    add_row(OP_ENQ,  32'h7fffffff, 16'h7fff, 1'b1, ST_OK,    1);
    add_row(OP_ENQ,  32'h80000000, 16'h8000, 1'b1, ST_OK,    2);
    add_row(OP_ENQ,  32'h00000000, 16'h0000, 1'b1, ST_OK,    3);
    add_row(OP_ENQ,  32'hffffffff, 16'h0000, 1'b1, ST_OK,    4);
    add_row(OP_ENQ,  32'h00000005, 16'h7fff, 1'b1, ST_OK,    5);
    add_row(OP_PEEK, 32'h0,        16'h0,    1'b0, ST_OK,    0);
    add_row(OP_DEQ,  32'h0,        16'h0,    1'b0, ST_OK,    0);
    add_row(OP_ENQ,  32'h55555555, 16'h0001, 1'b0, ST_OK,    0);
    add_row(OP_ENQ,  32'haaaaaaaa, 16'hfffe, 1'b0, ST_OK,    0);
    add_row(OP_ENQ,  32'h12345678, 16'h0000, 1'b0, ST_OK,    0);
    add_row(OP_ENQ,  32'h87654321, 16'h7fff, 1'b0, ST_OK,    0);
    add_row(OP_ENQ,  32'h0f0f0f0f, 16'h8000, 1'b0, ST_OK,    0);
    add_row(OP_ENQ,  32'hf0f0f0f0, 16'h1234, 1'b0, ST_OK,    0);
    add_row(OP_ENQ,  32'h00ff00ff, 16'hedcb, 1'b0, ST_OK,    0);
    add_row(OP_ENQ,  32'hff00ff00, 16'h0000, 1'b0, ST_OK,    0);
    add_row(OP_ENQ,  32'h00000001, 16'h0100, 1'b0, ST_OK,    0);
    add_row(OP_ENQ,  32'hdeadbeef, 16'hff00, 1'b0, ST_OK,    0);
    add_row(OP_ENQ,  32'h7ffffffe, 16'h8001, 1'b0, ST_OK,    0);
    add_row(OP_ENQ,  32'h80000001, 16'h7ffe, 1'b0, ST_OK,    0);
    add_row(OP_ENQ,  32'h13579bdf, 16'h5555, 1'b1, ST_OVERFLOW, 16);
    add_row(OP_NOP,  32'h0,        16'h0,    1'b1, ST_OK,    16);
    add_row(OP_PEEK, 32'h0,        16'h0,    1'b0, ST_OK,    0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].op, directed_rows[i].data, directed_rows[i].prio, 6,
               directed_rows[i].pinned, directed_rows[i].want);
    end

    // Random traffic in stretches that lean toward filling, draining or a mix,
    // so that full and empty are both reached again and again.
    for (int n = 0; n < 925; n++) begin
      if (n < 310) idle_pct = 6;
      else if (n < 620) idle_pct = 65;
      else idle_pct = 0;

      if (mix_left == 0) begin
        mix      = mix_e'($urandom_range(0, 2));
        mix_left = $urandom_range(10, 40);
      end
      mix_left--;
      case (mix)
        FILLING:  enq_pct = 75;
        DRAINING: enq_pct = 15;
        default:  enq_pct = 45;
      endcase
      peek_pct = 10;

      roll = $urandom_range(99);
      if (roll < 5) op = OP_NOP;
      else if (roll < 5 + enq_pct) op = OP_ENQ;
      else if (roll < 5 + enq_pct + peek_pct) op = OP_PEEK;
      else op = OP_DEQ;

      // Many priorities come from a narrow band so that ties are common.
      roll = $urandom_range(99);
      if (roll < 35) begin
        p = PRIO_W'($urandom_range(0, 4)) - PRIO_W'(2);
      end else if (roll < 50) begin
        case ($urandom_range(0, 3))
          0:       p = 16'sh8000;
          1:       p = 16'sh7fff;
          2:       p = 16'sh0000;
          default: p = 16'shffff;
        endcase
      end else begin
        p = PRIO_W'($urandom);
      end

      if ($urandom_range(99) < 10) d = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      else d = $urandom;

      send_cmd(op, d, p, idle_pct, 1'b0, no_pin);
    end

    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (2 * DEPTH + 4) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: sorted_priority_queue.f
design/spq_pkg.sv
design/spq_ram.sv
design/spq_dp.sv
design/spq_ctrl.sv
design/sorted_priority_queue.sv
design/spq_checker.sv
verif/tb_top.sv
